// File: rtl/core/scp_pkg.sv
// Shared types and constants for the sorted codepoint set.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package scp_pkg;

    localparam int CAPACITY_DEF = 128;

    localparam logic [20:0] LOWEST_CP  = 21'h00020;
    localparam logic [20:0] HIGHEST_CP = 21'h0FFFF;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_DONE      = 3'd4
    } status_t;

    // What the token walking down the cell row is doing.
    typedef enum logic {
        TOK_INS  = 1'b0,
        TOK_READ = 1'b1
    } tok_op_t;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_CARRY  = 2'd1,
        MODE_FINISH = 2'd2
    } tok_mode_t;

    typedef struct packed {
        logic        active;
        tok_op_t     op;
        tok_mode_t   mode;
        status_t     status;
        logic [15:0] value;
        logic [6:0]  index;
    } tok_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_BUSY = 1'b1
    } fsm_t;

endpackage

// File: rtl/core/scp_cell.sv
// One cell of the sorted set row: holds a single entry and forwards the token.
// Depends on scp_pkg for the token type and status codes.
`timescale 1ns / 1ps

module scp_cell #(
    parameter int CAPACITY = scp_pkg::CAPACITY_DEF,
    parameter int IDX      = 0,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scp_pkg::tok_t    tok_in,
    input  logic [CNT_W-1:0] count,
    output scp_pkg::tok_t    tok_out
);
    import scp_pkg::*;

    logic [15:0] entry_reg;
    logic [15:0] entry_next;
    logic        entry_wr;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        occupied;
    logic        full;
    logic        at_index;

    assign occupied = 32'(IDX) < 32'(count);
    assign full     = 32'(count) == 32'(CAPACITY);
    assign at_index = 32'(tok_in.index) == 32'(IDX);

    always_comb
    begin
        tok_next   = tok_in;
        entry_next = tok_in.value;
        entry_wr   = 1'b0;
        if (tok_in.active && tok_in.mode != MODE_FINISH)
        begin
            case (tok_in.op)
                TOK_INS:
                begin
                    if (!occupied)
                    begin
                        // first free slot: drop the carried value here
                        entry_wr        = 1'b1;
                        tok_next.mode   = MODE_FINISH;
                        tok_next.status = ST_INSERTED;
                    end
                    else if (tok_in.mode == MODE_CARRY)
                    begin
                        entry_wr       = 1'b1;
                        tok_next.value = entry_reg;
                    end
                    else if (entry_reg == tok_in.value)
                    begin
                        tok_next.mode   = MODE_FINISH;
                        tok_next.status = ST_DUPLICATE;
                    end
                    else if (entry_reg > tok_in.value)
                    begin
                        // later entries are larger, so no duplicate can follow
                        if (full)
                        begin
                            tok_next.mode   = MODE_FINISH;
                            tok_next.status = ST_FULL;
                        end
                        else
                        begin
                            entry_wr       = 1'b1;
                            tok_next.value = entry_reg;
                            tok_next.mode  = MODE_CARRY;
                        end
                    end
                end
                default:
                begin
                    if (at_index)
                    begin
                        tok_next.mode   = MODE_FINISH;
                        tok_next.status = ST_DONE;
                        tok_next.value  = occupied ? entry_reg : 16'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_wr)
        begin
            entry_reg <= entry_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/core/sorted_codepoint_set_insert.sv
// Sorted codepoint set: an ascending set of distinct 16-bit codepoints held in a
// row of CAPACITY cells. Insert and read requests send a token down the whole
// row, one cell per cycle, and their result is registered once the token leaves
// the last cell. Clear, the unused opcode and an out-of-range insert answer in
// the next cycle. One request is in flight at a time, and req_ready stays low
// while a request walks the row or a result waits on the response port.
// Depends on scp_pkg and scp_cell.
`timescale 1ns / 1ps

module sorted_codepoint_set_insert #(
    parameter int CAPACITY = scp_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  opcode,
    input  logic [20:0] codepoint,
    input  logic [6:0]  read_index,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  status,
    output logic        changed,
    output logic [7:0]  entry_count,
    output logic [15:0] read_value
);
    import scp_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    fsm_t             state_reg;
    fsm_t             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic             changed_reg;
    logic             changed_next;
    logic [7:0]       entry_count_reg;
    logic [15:0]      read_value_reg;
    logic [15:0]      read_value_next;
    logic             load_rsp;
    logic             accept;
    tok_t             tok_head;
    tok_t             tok_link [0:CAPACITY];
    tok_t             tail;

    assign req_ready   = (state_reg == FSM_IDLE) && !rsp_valid_reg;
    assign accept      = req_valid && req_ready;
    assign tok_link[0] = tok_head;
    assign tail        = tok_link[CAPACITY];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        load_rsp        = 1'b0;
        status_next     = ST_DONE;
        changed_next    = 1'b0;
        read_value_next = 16'd0;

        tok_head        = '0;
        tok_head.mode   = MODE_SEARCH;
        tok_head.status = ST_DONE;
        tok_head.value  = codepoint[15:0];
        tok_head.index  = read_index;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_INSERT:
                        begin
                            if (codepoint < LOWEST_CP || codepoint > HIGHEST_CP)
                            begin
                                load_rsp    = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                tok_head.active = 1'b1;
                                tok_head.op     = TOK_INS;
                                state_next      = FSM_BUSY;
                            end
                        end
                        OP_CLEAR:
                        begin
                            load_rsp   = 1'b1;
                            count_next = '0;
                        end
                        OP_READ:
                        begin
                            tok_head.active = 1'b1;
                            tok_head.op     = TOK_READ;
                            state_next      = FSM_BUSY;
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            FSM_BUSY:
            begin
                if (tail.active)
                begin
                    load_rsp   = 1'b1;
                    state_next = FSM_IDLE;
                    if (tail.mode == MODE_FINISH)
                    begin
                        status_next = tail.status;
                    end
                    else if (tail.op == TOK_INS)
                    begin
                        // walked past every entry without a free slot
                        status_next = ST_FULL;
                    end
                    if (tail.op == TOK_READ && tail.mode == MODE_FINISH)
                    begin
                        read_value_next = tail.value;
                    end
                    if (tail.op == TOK_INS && tail.mode == MODE_FINISH
                        && tail.status == ST_INSERTED)
                    begin
                        changed_next = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        rsp_valid_next = load_rsp || (rsp_valid_reg && !rsp_ready);
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        scp_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_link[i]),
            .count   (count_reg),
            .tok_out (tok_link[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            status_reg      <= status_next;
            changed_reg     <= changed_next;
            entry_count_reg <= 8'(count_next);
            read_value_reg  <= read_value_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign changed     = changed_reg;
    assign entry_count = entry_count_reg;
    assign read_value  = read_value_reg;

endmodule

// File: rtl/core/scp_checker.sv
// Port-level checks for the sorted codepoint set, bound to the top level.
// Depends on scp_pkg for status codes and the default capacity.
`timescale 1ns / 1ps

module scp_checker #(
    parameter int CAPACITY = scp_pkg::CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic        changed,
    input logic [7:0]  entry_count,
    input logic [15:0] read_value
);
    import scp_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(entry_count) && $stable(read_value))
        else $error("response changed while stalled");

    a_changed_iff_inserted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (changed == (status == ST_INSERTED)))
        else $error("changed flag disagrees with status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL |-> entry_count == 8'(CAPACITY))
        else $error("full reported with set not at capacity");

    a_value_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_DONE |-> read_value == 16'd0)
        else $error("read value nonzero on an insert result");

    a_no_request_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while a result is pending");

endmodule

bind sorted_codepoint_set_insert scp_checker #(.CAPACITY(CAPACITY)) u_scp_checker (.*);
